/* hdl/dss_pkg.sv */
// Shared codes, constants and controller/datapath interface types for the disk seek scheduler.
`default_nettype none

package dss_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_DISK = 2'd1;
  localparam logic [1:0] CFG_HEAD = 2'd2;

  // Scheduling orders. Any other code is served in arrival order.
  localparam logic [1:0] MODE_SCAN  = 2'd1;
  localparam logic [1:0] MODE_CSCAN = 2'd2;

  // Kinds of head move reported on the result channel.
  localparam logic [1:0] KIND_REQ  = 2'd0;
  localparam logic [1:0] KIND_LAST = 2'd1;
  localparam logic [1:0] KIND_JUMP = 2'd2;

  // Operations on the request pointer.
  localparam logic [2:0] IDX_HOLD     = 3'd0;
  localparam logic [2:0] IDX_INC      = 3'd1;
  localparam logic [2:0] IDX_DEC      = 3'd2;
  localparam logic [2:0] IDX_CLEAR    = 3'd3;
  localparam logic [2:0] IDX_SPLIT_M1 = 3'd4;

  localparam int TOTAL_W    = 22;
  localparam int DISK_RESET = 200;

  typedef struct packed {
    logic       load;
    logic       setup;
    logic       split_save;
    logic [2:0] idx_op;
    logic       ram_rd;
    logic       emit;
    logic [1:0] kind;
    logic       use_ram;
    logic       final_beat;
    logic       batch_done;
  } dss_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic mode_scan;
    logic mode_cscan;
    logic idx_lt_cnt;
    logic find_stop;
    logic split_zero;
    logic idx_zero;
    logic idx_last_cnt;
    logic idx_last_split;
  } dss_status_t;

endpackage

`default_nettype wire

/* hdl/dss_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

/* hdl/dss_sort_chain.sv */
// Insertion sorting chain: keeps the held requests in ascending order, one insert per cycle.
`default_nettype none

module dss_sort_chain #(
  parameter int MAX_REQUESTS = 32,
  parameter int CYL_BITS     = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 ins_en,
  input  wire logic [CYL_BITS-1:0]                  ins_val,
  input  wire logic [$clog2(MAX_REQUESTS+1)-1:0]    count,
  input  wire logic [$clog2(MAX_REQUESTS)-1:0]      rd_idx,
  output logic      [CYL_BITS-1:0]                  rd_val
);

  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

  logic [CYL_BITS-1:0]     s_r [MAX_REQUESTS];
  logic [MAX_REQUESTS-1:0] gt;

  genvar i;
  for (i = 0; i < MAX_REQUESTS; i++) begin : g_cell
    logic                prev_gt;
    logic [CYL_BITS-1:0] prev_val;
    logic [CYL_BITS-1:0] cell_nxt;

    if (i == 0) begin : g_first
      assign prev_gt  = 1'b0;
      assign prev_val = ins_val;
    end else begin : g_rest
      assign prev_gt  = gt[i-1];
      assign prev_val = s_r[i-1];
    end

    // A held entry larger than the new value moves up by one place.
    assign gt[i] = (CNT_W'(i) < count) && (s_r[i] > ins_val);

    always_comb begin
      cell_nxt = s_r[i];
      if (ins_en && (CNT_W'(i) <= count)) begin
        if (prev_gt) begin
          cell_nxt = prev_val;
        end else if (gt[i] || (CNT_W'(i) == count)) begin
          cell_nxt = ins_val;
        end
      end
    end

    always_ff @(posedge clk) begin
      s_r[i] <= cell_nxt;
    end
  end

  assign rd_val = (int'(rd_idx) < MAX_REQUESTS) ? s_r[rd_idx] : '0;

endmodule

`default_nettype wire

/* hdl/dss_ctrl.sv */
// Controller state machine: sequences loading, split search and the move passes of each mode.
`default_nettype none

module dss_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_batch_end,
  input  wire dss_pkg::dss_status_t status,
  output logic                      in_stall,
  output dss_pkg::dss_cmd_t         cmd
);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_SETUP = 4'd1;
  localparam logic [3:0] S_FIND  = 4'd2;
  localparam logic [3:0] S_UP    = 4'd3;
  localparam logic [3:0] S_JUMP  = 4'd4;
  localparam logic [3:0] S_CUP   = 4'd5;
  localparam logic [3:0] S_DOWN  = 4'd6;
  localparam logic [3:0] S_FRD   = 4'd7;
  localparam logic [3:0] S_FEM   = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_stall = (state_r != S_LOAD);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_batch_end) begin
            state_nxt = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        cmd.idx_op = dss_pkg::IDX_CLEAR;
        state_nxt  = (status.mode_scan || status.mode_cscan) ? S_FIND : S_FRD;
      end
      S_FIND: begin
        if (status.find_stop) begin
          cmd.split_save = 1'b1;
          state_nxt      = S_UP;
        end else begin
          cmd.idx_op = dss_pkg::IDX_INC;
        end
      end
      S_UP: begin
        if (status.slot_free) begin
          cmd.emit = 1'b1;
          if (status.idx_lt_cnt) begin
            cmd.kind   = dss_pkg::KIND_REQ;
            cmd.idx_op = dss_pkg::IDX_INC;
          end else begin
            cmd.kind = dss_pkg::KIND_LAST;
            if (status.mode_cscan) begin
              state_nxt = S_JUMP;
            end else if (status.split_zero) begin
              cmd.final_beat = 1'b1;
              cmd.batch_done = 1'b1;
              state_nxt      = S_LOAD;
            end else begin
              cmd.idx_op = dss_pkg::IDX_SPLIT_M1;
              state_nxt  = S_DOWN;
            end
          end
        end
      end
      S_JUMP: begin
        if (status.slot_free) begin
          cmd.emit = 1'b1;
          cmd.kind = dss_pkg::KIND_JUMP;
          if (status.split_zero) begin
            cmd.final_beat = 1'b1;
            cmd.batch_done = 1'b1;
            state_nxt      = S_LOAD;
          end else begin
            cmd.idx_op = dss_pkg::IDX_CLEAR;
            state_nxt  = S_CUP;
          end
        end
      end
      S_CUP: begin
        if (status.slot_free) begin
          cmd.emit = 1'b1;
          cmd.kind = dss_pkg::KIND_REQ;
          if (status.idx_last_split) begin
            cmd.final_beat = 1'b1;
            cmd.batch_done = 1'b1;
            state_nxt      = S_LOAD;
          end else begin
            cmd.idx_op = dss_pkg::IDX_INC;
          end
        end
      end
      S_DOWN: begin
        if (status.slot_free) begin
          cmd.emit = 1'b1;
          cmd.kind = dss_pkg::KIND_REQ;
          if (status.idx_zero) begin
            cmd.final_beat = 1'b1;
            cmd.batch_done = 1'b1;
            state_nxt      = S_LOAD;
          end else begin
            cmd.idx_op = dss_pkg::IDX_DEC;
          end
        end
      end
      S_FRD: begin
        cmd.ram_rd = 1'b1;
        state_nxt  = S_FEM;
      end
      S_FEM: begin
        if (status.slot_free) begin
          cmd.emit    = 1'b1;
          cmd.kind    = dss_pkg::KIND_REQ;
          cmd.use_ram = 1'b1;
          if (status.idx_last_cnt) begin
            cmd.final_beat = 1'b1;
            cmd.batch_done = 1'b1;
            state_nxt      = S_LOAD;
          end else begin
            cmd.idx_op = dss_pkg::IDX_INC;
            state_nxt  = S_FRD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* hdl/dss_datapath.sv */
// Datapath: configuration, request stores, head and distance arithmetic and the result register.
`default_nettype none

module dss_datapath #(
  parameter int MAX_REQUESTS = 32,
  parameter int CYL_BITS     = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [CYL_BITS:0]                 cfg_data,
  input  wire logic [CYL_BITS-1:0]               in_cylinder,
  input  wire dss_pkg::dss_cmd_t                 cmd,
  output dss_pkg::dss_status_t                   status,
  input  wire logic                              out_stall,
  output logic                                   out_valid,
  output logic [1:0]                             out_move_kind,
  output logic [CYL_BITS-1:0]                    out_from_pos,
  output logic [CYL_BITS-1:0]                    out_to_pos,
  output logic [CYL_BITS-1:0]                    out_distance,
  output logic [dss_pkg::TOTAL_W-1:0]            out_total_distance,
  output logic [$clog2(MAX_REQUESTS+1)-1:0]      out_served_count,
  output logic                                   out_overflow,
  output logic                                   out_final_move
);

  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam int IDX_W = $clog2(MAX_REQUESTS);
  localparam int CFG_W = CYL_BITS + 1;
  localparam int TW    = dss_pkg::TOTAL_W;

  logic [1:0]          mode_r, mode_nxt;
  logic [CFG_W-1:0]    disk_r, disk_nxt;
  logic [CYL_BITS-1:0] hstart_r, hstart_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                dropped_r, dropped_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    split_r, split_nxt;
  logic [CYL_BITS-1:0] head_r, head_nxt;
  logic [CYL_BITS-1:0] last_r, last_nxt;
  logic [TW-1:0]       sum_r, sum_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [1:0]          kind_r;
  logic [CYL_BITS-1:0] from_r, to_r, dist_r;
  logic [TW-1:0]       total_r;
  logic [CNT_W-1:0]    served_r;
  logic                ovf_r, fin_r;

  logic                full;
  logic [CFG_W-1:0]    disk_m1;
  logic [CYL_BITS-1:0] last_c;
  logic [CYL_BITS-1:0] chain_val, ram_val;
  logic [CYL_BITS-1:0] sorted_c, fifo_c, req_c;
  logic [CYL_BITS-1:0] to_c, dist_c;
  logic [TW-1:0]       sum_add;
  logic [CNT_W-1:0]    idx_p1;

  assign full = (cnt_r == CNT_W'(MAX_REQUESTS));

  // A disk size of zero behaves as one cylinder, anything at or above the
  // addressable range as the full range.
  assign disk_m1 = disk_r - CFG_W'(1);
  assign last_c  = (disk_r == '0)      ? '0 :
                   disk_r[CYL_BITS]    ? {CYL_BITS{1'b1}} :
                                         disk_m1[CYL_BITS-1:0];

  dss_sort_chain #(
    .MAX_REQUESTS (MAX_REQUESTS),
    .CYL_BITS     (CYL_BITS)
  ) u_chain (
    .clk     (clk),
    .ins_en  (cmd.load && !full),
    .ins_val (in_cylinder),
    .count   (cnt_r),
    .rd_idx  (idx_r[IDX_W-1:0]),
    .rd_val  (chain_val)
  );

  dss_ram #(
    .WIDTH (CYL_BITS),
    .DEPTH (MAX_REQUESTS)
  ) u_store (
    .clk     (clk),
    .we      (cmd.load && !full),
    .waddr   (cnt_r[IDX_W-1:0]),
    .wdata   (in_cylinder),
    .re      (cmd.ram_rd),
    .raddr   (idx_r[IDX_W-1:0]),
    .rdata_r (ram_val)
  );

  assign sorted_c = (chain_val > last_r) ? last_r : chain_val;
  assign fifo_c   = (ram_val > last_r) ? last_r : ram_val;
  assign req_c    = cmd.use_ram ? fifo_c : sorted_c;
  assign idx_p1   = idx_r + CNT_W'(1);

  always_comb begin
    case (cmd.kind)
      dss_pkg::KIND_REQ: begin
        to_c   = req_c;
        dist_c = (req_c > head_r) ? (req_c - head_r) : (head_r - req_c);
      end
      dss_pkg::KIND_LAST: begin
        to_c   = last_r;
        dist_c = last_r - head_r;
      end
      default: begin
        to_c   = '0;
        dist_c = last_r;
      end
    endcase
  end

  assign sum_add = sum_r + TW'(dist_c);

  always_comb begin
    status.slot_free      = !out_valid_r || !out_stall;
    status.mode_scan      = (mode_r == dss_pkg::MODE_SCAN);
    status.mode_cscan     = (mode_r == dss_pkg::MODE_CSCAN);
    status.idx_lt_cnt     = (idx_r < cnt_r);
    status.find_stop      = !(idx_r < cnt_r) || (sorted_c > head_r);
    status.split_zero     = (split_r == '0);
    status.idx_zero       = (idx_r == '0);
    status.idx_last_cnt   = (idx_p1 == cnt_r);
    status.idx_last_split = (idx_p1 == split_r);
  end

  always_comb begin
    mode_nxt   = mode_r;
    disk_nxt   = disk_r;
    hstart_nxt = hstart_r;
    if (cfg_we) begin
      case (cfg_index)
        dss_pkg::CFG_MODE: mode_nxt   = cfg_data[1:0];
        dss_pkg::CFG_DISK: disk_nxt   = cfg_data;
        dss_pkg::CFG_HEAD: hstart_nxt = cfg_data[CYL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    dropped_nxt = dropped_r;
    split_nxt   = cmd.split_save ? idx_r : split_r;
    head_nxt    = head_r;
    last_nxt    = last_r;
    sum_nxt     = sum_r;
    if (cmd.load) begin
      if (full) begin
        dropped_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
    if (cmd.setup) begin
      last_nxt = last_c;
      head_nxt = (hstart_r > last_c) ? last_c : hstart_r;
      sum_nxt  = '0;
    end
    if (cmd.emit) begin
      head_nxt = to_c;
      sum_nxt  = sum_add;
    end
    if (cmd.batch_done) begin
      cnt_nxt     = '0;
      dropped_nxt = 1'b0;
      sum_nxt     = '0;
    end
  end

  always_comb begin
    case (cmd.idx_op)
      dss_pkg::IDX_INC:      idx_nxt = idx_p1;
      dss_pkg::IDX_DEC:      idx_nxt = idx_r - CNT_W'(1);
      dss_pkg::IDX_CLEAR:    idx_nxt = '0;
      dss_pkg::IDX_SPLIT_M1: idx_nxt = split_r - CNT_W'(1);
      default:               idx_nxt = idx_r;
    endcase
  end

  assign out_valid_nxt = cmd.emit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= dss_pkg::MODE_SCAN;
      disk_r      <= CFG_W'(dss_pkg::DISK_RESET);
      hstart_r    <= '0;
      cnt_r       <= '0;
      dropped_r   <= 1'b0;
      idx_r       <= '0;
      split_r     <= '0;
      head_r      <= '0;
      last_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      disk_r      <= disk_nxt;
      hstart_r    <= hstart_nxt;
      cnt_r       <= cnt_nxt;
      dropped_r   <= dropped_nxt;
      idx_r       <= idx_nxt;
      split_r     <= split_nxt;
      head_r      <= head_nxt;
      last_r      <= last_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind_r   <= cmd.kind;
      from_r   <= head_r;
      to_r     <= to_c;
      dist_r   <= dist_c;
      total_r  <= sum_add;
      served_r <= cnt_r;
      ovf_r    <= dropped_r;
      fin_r    <= cmd.final_beat;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_move_kind      = kind_r;
  assign out_from_pos       = from_r;
  assign out_to_pos         = to_r;
  assign out_distance       = dist_r;
  assign out_total_distance = total_r;
  assign out_served_count   = served_r;
  assign out_overflow       = ovf_r;
  assign out_final_move     = fin_r;

endmodule

`default_nettype wire

/* hdl/disk_seek_scheduler.sv */
// Top level of the batch disk seek scheduler (FCFS, SCAN and C-SCAN orders).
// Loading: one request beat is taken per cycle; a beat without batch_end yields no result.
// Scheduling: after the batch_end beat comes a setup state; SCAN and C-SCAN then search the
// sorted chain for the first request above the head and emit one move per cycle while
// out_stall is low; FCFS reads the registered store before each move that it emits.
// Reset is synchronous and active low: it clears control state and restores the
// register defaults (scan order, 200 cylinders, head at 0); the request store is not cleared.
`default_nettype none

module disk_seek_scheduler #(
  parameter int MAX_REQUESTS = 32,
  parameter int CYL_BITS     = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [CYL_BITS:0]                 cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [CYL_BITS-1:0]               in_cylinder,
  input  wire logic                              in_batch_end,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [1:0]                             out_move_kind,
  output logic [CYL_BITS-1:0]                    out_from_pos,
  output logic [CYL_BITS-1:0]                    out_to_pos,
  output logic [CYL_BITS-1:0]                    out_distance,
  output logic [dss_pkg::TOTAL_W-1:0]            out_total_distance,
  output logic [$clog2(MAX_REQUESTS+1)-1:0]      out_served_count,
  output logic                                   out_overflow,
  output logic                                   out_final_move
);

  // The controller decides what happens each cycle; the datapath holds every
  // stored value and reports back only the comparisons the controller needs.
  dss_pkg::dss_cmd_t    cmd;
  dss_pkg::dss_status_t status;

  // The controller owns the input handshake: a beat is taken only while it is
  // loading. The result register sits in the datapath, so a new batch may start
  // loading while the final move of the previous one still waits to be taken.
  dss_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_batch_end (in_batch_end),
    .status       (status),
    .in_stall     (in_stall),
    .cmd          (cmd)
  );

  // Requests are written both into the arrival-order store (used for FCFS) and
  // into the sorting chain (used for both sweep orders). Clamping to the last
  // cylinder is applied when a request is read out, since the disk size may be
  // rewritten between the beats of a batch; clamping keeps the sorted order.
  dss_datapath #(
    .MAX_REQUESTS (MAX_REQUESTS),
    .CYL_BITS     (CYL_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_cylinder        (in_cylinder),
    .cmd                (cmd),
    .status             (status),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_move_kind      (out_move_kind),
    .out_from_pos       (out_from_pos),
    .out_to_pos         (out_to_pos),
    .out_distance       (out_distance),
    .out_total_distance (out_total_distance),
    .out_served_count   (out_served_count),
    .out_overflow       (out_overflow),
    .out_final_move     (out_final_move)
  );

  // The final request beat of a batch must stop further loading while it is served.
  a_batch_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_batch_end) |=> in_stall)
    else $error("input not stalled after the batch end beat");

  // Every reported move belongs to a batch holding between one and the capacity.
  a_served_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_served_count != '0) &&
                   (int'(out_served_count) <= MAX_REQUESTS)))
    else $error("served count out of range");

  // Apart from the jump to cylinder zero, the distance is the span between the ends.
  a_distance_span: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_move_kind != dss_pkg::KIND_JUMP)) |->
      (out_distance == ((out_to_pos > out_from_pos) ? (out_to_pos - out_from_pos)
                                                    : (out_from_pos - out_to_pos))))
    else $error("move distance does not match its end points");

  // A move issued by the controller always lands in a free result register.
  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> status.slot_free)
    else $error("move issued while the result register is occupied");

endmodule

`default_nettype wire
